/* hdl/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// fpa_pkg
// Types, operation and status codes, and helpers for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int NUM_W = 50;

    localparam logic [3:0] OP_ADD      = 4'd0;
    localparam logic [3:0] OP_SUB      = 4'd1;
    localparam logic [3:0] OP_MUL      = 4'd2;
    localparam logic [3:0] OP_DIV      = 4'd3;
    localparam logic [3:0] OP_GT       = 4'd4;
    localparam logic [3:0] OP_LT       = 4'd5;
    localparam logic [3:0] OP_GE       = 4'd6;
    localparam logic [3:0] OP_LE       = 4'd7;
    localparam logic [3:0] OP_EQ       = 4'd8;
    localparam logic [3:0] OP_NE       = 4'd9;
    localparam logic [3:0] OP_MIN      = 4'd10;
    localparam logic [3:0] OP_MAX      = 4'd11;
    localparam logic [3:0] OP_INC      = 4'd12;
    localparam logic [3:0] OP_DEC      = 4'd13;
    localparam logic [3:0] OP_FROM_INT = 4'd14;
    localparam logic [3:0] OP_TO_INT   = 4'd15;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OVF = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    localparam logic [31:0] MAX32 = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN32 = 32'h8000_0000;

    typedef struct packed {
        logic [3:0]         operation;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_in;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               compare_true;
        logic [1:0]         status;
    } t_out;

    typedef struct packed {
        logic [31:0] value;
        logic        ovf;
    } t_sat;

    typedef struct packed {
        logic [3:0]       op;
        logic [31:0]      res;
        logic             flag;
        logic [1:0]       status;
        logic             neg;
        logic             a_neg;
        logic             dz;
        logic             dovf;
        logic [NUM_W-1:0] num;
        logic [32:0]      den;
        logic [32:0]      rem;
        logic [31:0]      quo;
        logic [31:0]      mag_a;
        logic [31:0]      mag_b;
        logic [63:0]      prod;
        logic [31:0]      fmag;
        logic             fovf;
    } t_pipe;

    function automatic t_sat sat33(input logic [32:0] v);
        t_sat s;
        s.ovf   = v[32] ^ v[31];
        s.value = s.ovf ? (v[32] ? MIN32 : MAX32) : v[31:0];
        return s;
    endfunction

endpackage

/* hdl/fpa_front.sv */
// ----------------------------------------------------------------------------
// fpa_front
// Decode stage for simple operations and operand magnitudes, then a setup
// stage with the multiplier and the divider range check.
// ----------------------------------------------------------------------------
module fpa_front #(
    parameter int FRAC_BITS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  fpa_pkg::t_in     i_data,
    output logic             o_ready,
    output logic             o_valid,
    output fpa_pkg::t_pipe   o_data,
    input  logic             i_ready
);

    logic                 r_a_valid;
    fpa_pkg::t_pipe       r_a;
    fpa_pkg::t_pipe       n_a;
    logic                 r_b_valid;
    fpa_pkg::t_pipe       r_b;
    fpa_pkg::t_pipe       n_b;
    logic                 ready_a;
    logic                 ready_b;
    logic signed [31:0]   a;
    logic signed [31:0]   b;
    logic signed [63:0]   fi;
    fpa_pkg::t_sat        s_add;
    fpa_pkg::t_sat        s_sub;
    fpa_pkg::t_sat        s_inc;
    fpa_pkg::t_sat        s_dec;
    logic [31:0]          mag_a;
    logic [31:0]          mag_b;

    assign a       = i_data.operand_a;
    assign b       = i_data.operand_b;
    assign fi      = 64'(a) <<< FRAC_BITS;
    assign s_add   = fpa_pkg::sat33({a[31], a} + {b[31], b});
    assign s_sub   = fpa_pkg::sat33({a[31], a} - {b[31], b});
    assign s_inc   = fpa_pkg::sat33({a[31], a} + 33'd1);
    assign s_dec   = fpa_pkg::sat33({a[31], a} - 33'd1);
    assign mag_a   = a[31] ? 32'(-a) : 32'(a);
    assign mag_b   = b[31] ? 32'(-b) : 32'(b);

    always_comb begin
        n_a        = '0;
        n_a.op     = i_data.operation;
        n_a.neg    = a[31] ^ b[31];
        n_a.a_neg  = a[31];
        n_a.dz     = (b == 32'sd0);
        n_a.mag_a  = mag_a;
        n_a.mag_b  = mag_b;
        n_a.num    = ({18'b0, mag_a} << (FRAC_BITS + 1)) + {18'b0, mag_b};
        n_a.den    = {mag_b, 1'b0};
        case (i_data.operation)
            fpa_pkg::OP_ADD: begin
                n_a.res    = s_add.value;
                n_a.status = s_add.ovf ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
            end
            fpa_pkg::OP_SUB: begin
                n_a.res    = s_sub.value;
                n_a.status = s_sub.ovf ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
            end
            fpa_pkg::OP_GT: n_a.flag = (a > b);
            fpa_pkg::OP_LT: n_a.flag = (a < b);
            fpa_pkg::OP_GE: n_a.flag = (a >= b);
            fpa_pkg::OP_LE: n_a.flag = (a <= b);
            fpa_pkg::OP_EQ: n_a.flag = (a == b);
            fpa_pkg::OP_NE: n_a.flag = (a != b);
            fpa_pkg::OP_MIN: n_a.res = (a < b) ? a : b;
            fpa_pkg::OP_MAX: n_a.res = (a > b) ? a : b;
            fpa_pkg::OP_INC: begin
                n_a.res    = s_inc.value;
                n_a.status = s_inc.ovf ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
            end
            fpa_pkg::OP_DEC: begin
                n_a.res    = s_dec.value;
                n_a.status = s_dec.ovf ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
            end
            fpa_pkg::OP_FROM_INT: begin
                if (fi[63:31] != {33{fi[63]}}) begin
                    n_a.res    = fi[63] ? fpa_pkg::MIN32 : fpa_pkg::MAX32;
                    n_a.status = fpa_pkg::ST_OVF;
                end else begin
                    n_a.res    = fi[31:0];
                end
            end
            fpa_pkg::OP_TO_INT: n_a.res = 32'(a >>> FRAC_BITS);
            default: n_a.res = '0;
        endcase
    end

    always_comb begin
        n_b      = r_a;
        n_b.prod = r_a.mag_a * r_a.mag_b;
        n_b.dovf = ({15'b0, r_a.num[fpa_pkg::NUM_W-1:32]} >= r_a.den);
        n_b.rem  = {15'b0, r_a.num[fpa_pkg::NUM_W-1:32]};
        n_b.quo  = '0;
    end

    assign ready_b = !r_b_valid || i_ready;
    assign ready_a = !r_a_valid || ready_b;
    assign o_ready = ready_a;
    assign o_valid = r_b_valid;
    assign o_data  = r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (ready_a) r_a_valid <= i_valid;
            if (ready_b) r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a && i_valid) r_a <= n_a;
        if (ready_b && r_a_valid) r_b <= n_b;
    end

endmodule

/* hdl/fpa_div_step.sv */
// ----------------------------------------------------------------------------
// fpa_div_step
// One restoring division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
module fpa_div_step #(
    parameter int STEP = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  fpa_pkg::t_pipe   i_data,
    output logic             o_ready,
    output logic             o_valid,
    output fpa_pkg::t_pipe   o_data,
    input  logic             i_ready
);

    localparam int BIT = 31 - STEP;

    logic             r_valid;
    fpa_pkg::t_pipe   r_data;
    fpa_pkg::t_pipe   n_data;
    logic [33:0]      trial;
    logic [33:0]      diff;
    logic             qbit;

    assign trial = {i_data.rem, i_data.num[BIT]};
    assign diff  = trial - {1'b0, i_data.den};
    assign qbit  = (trial >= {1'b0, i_data.den});

    always_comb begin
        n_data     = i_data;
        n_data.rem = qbit ? diff[32:0] : trial[32:0];
        n_data.quo = {i_data.quo[30:0], qbit};
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_data <= n_data;
    end

endmodule

/* hdl/fpa_back.sv */
// ----------------------------------------------------------------------------
// fpa_back
// Rounding and range check for multiply and divide, then sign, saturation
// and the output register.
// ----------------------------------------------------------------------------
module fpa_back #(
    parameter int FRAC_BITS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  fpa_pkg::t_pipe   i_data,
    output logic             o_ready,
    output logic             o_valid,
    output fpa_pkg::t_out    o_data,
    input  logic             i_ready
);

    logic             r_a_valid;
    fpa_pkg::t_pipe   r_a;
    fpa_pkg::t_pipe   n_a;
    logic             r_b_valid;
    fpa_pkg::t_out    r_b;
    fpa_pkg::t_out    n_b;
    logic             ready_a;
    logic             ready_b;
    logic [63:0]      rounded;
    logic [63:0]      mag;

    assign rounded = (i_data.prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    assign mag     = (i_data.op == fpa_pkg::OP_MUL) ? rounded : {32'b0, i_data.quo};

    always_comb begin
        n_a      = i_data;
        n_a.fmag = mag[31:0];
        n_a.fovf = (i_data.op == fpa_pkg::OP_DIV && i_data.dovf)
                   || (i_data.neg ? (mag > 64'h8000_0000) : (mag > 64'h7FFF_FFFF));
    end

    always_comb begin
        n_b.result_value = r_a.res;
        n_b.compare_true = r_a.flag;
        n_b.status       = r_a.status;
        if (r_a.op == fpa_pkg::OP_MUL || r_a.op == fpa_pkg::OP_DIV) begin
            if (r_a.op == fpa_pkg::OP_DIV && r_a.dz) begin
                n_b.result_value = r_a.a_neg ? fpa_pkg::MIN32 : fpa_pkg::MAX32;
                n_b.status       = fpa_pkg::ST_DZ;
            end else if (r_a.fovf) begin
                n_b.result_value = r_a.neg ? fpa_pkg::MIN32 : fpa_pkg::MAX32;
                n_b.status       = fpa_pkg::ST_OVF;
            end else begin
                n_b.result_value = r_a.neg ? 32'(-r_a.fmag) : r_a.fmag;
                n_b.status       = fpa_pkg::ST_OK;
            end
        end
    end

    assign ready_b = !r_b_valid || i_ready;
    assign ready_a = !r_a_valid || ready_b;
    assign o_ready = ready_a;
    assign o_valid = r_b_valid;
    assign o_data  = r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (ready_a) r_a_valid <= i_valid;
            if (ready_b) r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a && i_valid) r_a <= n_a;
        if (ready_b && r_a_valid) r_b <= n_b;
    end

endmodule

/* hdl/fixed_point_alu_unit.sv */
// ----------------------------------------------------------------------------
// fixed_point_alu_unit
// Pipelined signed fixed-point ALU with saturation and status.
// ----------------------------------------------------------------------------
// Every request passes through all stages, whatever the operation, and
// one request can enter each cycle while o_in_stall is low. The divider
// has 32 restoring stages, one quotient bit each, between two front
// stages (decode, then multiplier and divider range check) and two
// back stages (rounding, then sign and saturation). Each stage holds its
// request while the next is full, so empty stages fill up under a stall.
module fixed_point_alu_unit #(
    parameter int FRAC_BITS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  fpa_pkg::t_in     i_in_data,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output fpa_pkg::t_out    o_out_data,
    input  logic             i_out_stall
);

    localparam int STEPS = 32;

    logic             front_ready;
    logic             step_valid [STEPS+1];
    fpa_pkg::t_pipe   step_data  [STEPS+1];
    logic             step_ready [STEPS+1];

    fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_ready (front_ready),
        .o_valid (step_valid[0]),
        .o_data  (step_data[0]),
        .i_ready (step_ready[0])
    );

    for (genvar k = 0; k < STEPS; k++) begin : g_div
        fpa_div_step #(.STEP(k)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (step_valid[k]),
            .i_data  (step_data[k]),
            .o_ready (step_ready[k]),
            .o_valid (step_valid[k+1]),
            .o_data  (step_data[k+1]),
            .i_ready (step_ready[k+1])
        );
    end

    fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (step_valid[STEPS]),
        .i_data  (step_data[STEPS]),
        .o_ready (step_ready[STEPS]),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_ready (!i_out_stall)
    );

    assign o_in_stall = !front_ready;

endmodule

/* hdl/fpa_checker.sv */
// ----------------------------------------------------------------------------
// fpa_checker
// Port-level checks for the fixed-point ALU, bound to the top level.
// ----------------------------------------------------------------------------
module fpa_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input fpa_pkg::t_in     i_in_data,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input fpa_pkg::t_out    o_out_data,
    input logic             i_out_stall
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status != 2'd3)
        else $error("unknown status code");

    a_compare_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.compare_true |->
            o_out_data.result_value == 32'sd0 && o_out_data.status == fpa_pkg::ST_OK)
        else $error("compare result carries value or status");

    a_dz_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == fpa_pkg::ST_DZ |->
            o_out_data.result_value == fpa_pkg::MAX32
            || o_out_data.result_value == fpa_pkg::MIN32)
        else $error("divide by zero not saturated");

endmodule

bind fixed_point_alu_unit fpa_checker u_fpa_checker (.*);
